// ===== rtl/core/ftflp_pkg.sv =====
package ftflp_pkg;

    localparam int WORD_BITS      = 32;
    localparam int WORDS_PER_LINE = 4;
    localparam int MAX_LANES      = 6;

    localparam int LANE_CNT_BITS = 3;
    localparam int WIDX_BITS     = 2;
    localparam int LWIDTH_BITS   = 6;
    localparam int MAG_BITS      = 56;

    localparam logic [WIDX_BITS-1:0] LAST_WIDX = WIDX_BITS'(WORDS_PER_LINE - 1);
    localparam logic [7:0]           EXP_SPECIAL = 8'hFF;

    // One result word with its place in the line.
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [WIDX_BITS-1:0] index;
        logic                 last;
    } out_word_t;

    // Effective lane count: zero acts as one, anything above the maximum clamps.
    function automatic logic [LANE_CNT_BITS-1:0] eff_lanes(input logic [LANE_CNT_BITS-1:0] n);
        logic [LANE_CNT_BITS-1:0] r;
        r = n;
        if (n == '0)
            r = LANE_CNT_BITS'(1);
        if (n > LANE_CNT_BITS'(MAX_LANES))
            r = LANE_CNT_BITS'(MAX_LANES);
        return r;
    endfunction

    // Lane width for a given lane count.
    function automatic logic [LWIDTH_BITS-1:0] lane_width(input logic [LANE_CNT_BITS-1:0] n);
        logic [LWIDTH_BITS-1:0] w;
        case (n)
            3'd1:    w = LWIDTH_BITS'(WORD_BITS / 1);
            3'd2:    w = LWIDTH_BITS'(WORD_BITS / 2);
            3'd3:    w = LWIDTH_BITS'(WORD_BITS / 3);
            3'd4:    w = LWIDTH_BITS'(WORD_BITS / 4);
            3'd5:    w = LWIDTH_BITS'(WORD_BITS / 5);
            3'd6:    w = LWIDTH_BITS'(WORD_BITS / 6);
            default: w = LWIDTH_BITS'(WORD_BITS);
        endcase
        return w;
    endfunction

    // Float to signed fixed point of width w with w/2 fraction bits,
    // truncating toward zero and saturating to the lane range.
    function automatic logic [WORD_BITS-1:0] convert(input logic [31:0] fb,
                                                     input logic [LWIDTH_BITS-1:0] w);
        logic                   neg;
        logic [7:0]             ex;
        logic [23:0]            man;
        logic signed [9:0]      sh;
        logic [4:0]             rsh;
        logic [MAG_BITS-1:0]    mag;
        logic [MAG_BITS-1:0]    lim;
        logic                   sat;
        logic                   nan;
        logic [WORD_BITS-1:0]   m32;
        logic [WORD_BITS-1:0]   mask;
        neg  = fb[31];
        ex   = fb[30:23];
        man  = {(ex != 8'd0), fb[22:0]};
        sh   = $signed({2'b00, ((ex == 8'd0) ? 8'd1 : ex)}) - 10'sd150
             + $signed({5'b00000, w[LWIDTH_BITS-1:1]});
        rsh  = 5'(-sh);
        lim  = MAG_BITS'(1) << (w - LWIDTH_BITS'(1));
        nan  = 1'b0;
        sat  = 1'b0;
        mag  = '0;
        if (ex == EXP_SPECIAL) begin
            nan = (fb[22:0] != 23'd0);
            sat = ~nan;
        end else if (sh >= 10'sd32) begin
            sat = 1'b1;
        end else if (sh >= 10'sd0) begin
            mag = MAG_BITS'(man) << sh[4:0];
        end else if (sh > -10'sd24) begin
            mag = MAG_BITS'(man) >> rsh;
        end
        if (!sat && !nan) begin
            if (neg && mag > lim)
                sat = 1'b1;
            if (!neg && mag >= lim)
                sat = 1'b1;
        end
        if (sat)
            mag = neg ? lim : lim - MAG_BITS'(1);
        m32 = mag[WORD_BITS-1:0];
        if (neg)
            m32 = WORD_BITS'(0) - m32;
        mask = WORD_BITS'((33'(1) << w) - 33'(1));
        return nan ? '0 : (m32 & mask);
    endfunction

endpackage

// ===== rtl/core/float_to_fixed_lane_packer.sv =====
// Converts one IEEE-754 single-precision value per cycle, unless stalled, to a
// signed fixed-point lane (width 32/lanes_per_word, half of it fraction bits,
// truncated toward zero, saturated, NaN as zero) and packs lanes from bit 0 upward
// into 32-bit words of four-word lines; completed words are registered. A flush
// request pads the line: it emits the pending word at once, then one
// zero word per cycle while the skid entry is empty, up to three, holding off
// new requests. A two-entry output stage (output register plus skid entry) lets
// requests flow while one result waits; the input stalls on a full skid or padding.
// Write lanes_per_word only while idle; a write discards the partial word.
module float_to_fixed_lane_packer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] float_bits,
    input  logic        flush,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] packed_word,
    output logic [1:0]  word_index,
    output logic        last_of_line,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [ftflp_pkg::LANE_CNT_BITS-1:0] lanes_reg, lanes_next;
    logic [ftflp_pkg::WORD_BITS-1:0]     acc_reg, acc_next;
    logic [ftflp_pkg::LANE_CNT_BITS-1:0] lane_reg, lane_next;
    logic [ftflp_pkg::WIDX_BITS-1:0]     wpos_reg, wpos_next;
    logic [ftflp_pkg::WIDX_BITS-1:0]     pad_reg, pad_next;
    logic                                ovalid_reg, ovalid_next;
    logic                                svalid_reg, svalid_next;
    ftflp_pkg::out_word_t                oword_reg, oword_next;
    ftflp_pkg::out_word_t                sword_reg, sword_next;

    logic                                accept;
    logic                                cfg_wr;
    logic                                push;
    logic [ftflp_pkg::WORD_BITS-1:0]     push_word;
    logic                                move;
    logic [ftflp_pkg::LANE_CNT_BITS-1:0] lanes;
    logic [ftflp_pkg::LWIDTH_BITS-1:0]   lwidth;
    logic [ftflp_pkg::WORD_BITS-1:0]     code;
    logic [ftflp_pkg::WORD_BITS-1:0]     merged;
    logic [ftflp_pkg::LANE_CNT_BITS-1:0] lane_inc;
    ftflp_pkg::out_word_t                push_item;

    // Handshakes and register port.
    assign in_stall  = svalid_reg | (pad_reg != '0);
    assign accept    = in_valid & ~in_stall;
    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite & (paddr == 3'd0);
    assign prdata    = (paddr == 3'd0) ? {29'd0, lanes_reg} : 32'd0;
    assign move      = ~ovalid_reg | ~out_stall;

    assign out_valid    = ovalid_reg;
    assign packed_word  = oword_reg.word;
    assign word_index   = oword_reg.index;
    assign last_of_line = oword_reg.last;

    // Conversion and lane placement.
    assign lanes    = ftflp_pkg::eff_lanes(lanes_reg);
    assign lwidth   = ftflp_pkg::lane_width(lanes);
    assign code     = ftflp_pkg::convert(float_bits, lwidth);
    assign merged   = acc_reg | (code << (lane_reg * 3'(1) * lwidth));
    assign lane_inc = lane_reg + ftflp_pkg::LANE_CNT_BITS'(1);

    // Word producer: configuration writes, data requests, flush requests and padding words.
    always_comb
    begin
        lanes_next = lanes_reg;
        acc_next   = acc_reg;
        lane_next  = lane_reg;
        pad_next   = pad_reg;
        push       = 1'b0;
        push_word  = acc_reg;
        if (cfg_wr) begin
            lanes_next = pwdata[2:0];
            acc_next   = '0;
            lane_next  = '0;
        end else if (pad_reg != '0) begin
            if (!svalid_reg) begin
                push      = 1'b1;
                push_word = '0;
                pad_next  = pad_reg - ftflp_pkg::WIDX_BITS'(1);
            end
        end else if (accept) begin
            if (flush) begin
                if (lane_reg != '0 || wpos_reg != '0) begin
                    push      = 1'b1;
                    push_word = acc_reg;
                    acc_next  = '0;
                    lane_next = '0;
                    pad_next  = ftflp_pkg::LAST_WIDX - wpos_reg;
                end
            end else if (lane_inc >= lanes) begin
                push      = 1'b1;
                push_word = merged;
                acc_next  = '0;
                lane_next = '0;
            end else begin
                acc_next  = merged;
                lane_next = lane_inc;
            end
        end
    end

    // Line position of the produced word.
    always_comb
    begin
        push_item.word  = push_word;
        push_item.index = wpos_reg;
        push_item.last  = (wpos_reg == ftflp_pkg::LAST_WIDX);
        wpos_next       = wpos_reg;
        if (push)
            wpos_next = push_item.last ? '0 : wpos_reg + ftflp_pkg::WIDX_BITS'(1);
    end

    // Output register with one skid entry.
    always_comb
    begin
        ovalid_next = ovalid_reg;
        svalid_next = svalid_reg;
        oword_next  = oword_reg;
        sword_next  = sword_reg;
        if (push) begin
            if (move) begin
                ovalid_next = 1'b1;
                oword_next  = push_item;
            end else begin
                svalid_next = 1'b1;
                sword_next  = push_item;
            end
        end else if (move) begin
            ovalid_next = svalid_reg;
            oword_next  = sword_reg;
            svalid_next = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lanes_reg  <= ftflp_pkg::LANE_CNT_BITS'(1);
            acc_reg    <= '0;
            lane_reg   <= '0;
            wpos_reg   <= '0;
            pad_reg    <= '0;
            ovalid_reg <= 1'b0;
            svalid_reg <= 1'b0;
        end else begin
            lanes_reg  <= lanes_next;
            acc_reg    <= acc_next;
            lane_reg   <= lane_next;
            wpos_reg   <= wpos_next;
            pad_reg    <= pad_next;
            ovalid_reg <= ovalid_next;
            svalid_reg <= svalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        oword_reg <= oword_next;
        sword_reg <= sword_next;
    end

endmodule
